[sv/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants, register codes and pipeline control types for the
// quaternion vector rotate unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // quaternion components are fixed 16-bit signed fixed point
    localparam int QUAT_BITS          = 16;
    localparam int VEC_WIDTH_DEF      = 16;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // rotation matrix entries: sums of 16x16 products, doubled
    localparam int MAT_W = 2 * QUAT_BITS + 2;

    // APB side
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // pipeline depth from input transfer to result register
    localparam int NSTG = 5;

    localparam logic signed [QUAT_BITS-1:0] QUAT_W_RESET = 16'sd16384;
    localparam logic signed [QUAT_BITS-1:0] QUAT_V_RESET = 16'sd0;

    typedef enum logic [1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } reg_idx_t;

    // load enables for a module that holds two pipeline stages
    typedef struct packed {
        logic en_a;
        logic en_b;
    } stg_ctrl_t;

endpackage

[sv/quaternion_vector_rotate_unit.sv]
// Throughput: one vector per clock unless the output stalls; five register
// stages, each with its own valid bit, so a stalled output fills empty
// stages before input is held.
// Reset: rst_n clears all stage valid bits and loads the identity quaternion
// (w = 16384, x = y = z = 0); datapath registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates each input 3-vector by the quaternion held in four APB registers,
// with round-to-nearest and saturation of the result components.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0]    paddr,
    input  logic [qvr_pkg::DATA_W-1:0]    pwdata,
    output logic [qvr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input vectors
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VEC_WIDTH-1:0]   vec_x,
    input  logic signed [VEC_WIDTH-1:0]   vec_y,
    input  logic signed [VEC_WIDTH-1:0]   vec_z,
    input  logic                          last_vector,
    // rotated vectors
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VEC_WIDTH-1:0]   rot_x,
    output logic signed [VEC_WIDTH-1:0]   rot_y,
    output logic signed [VEC_WIDTH-1:0]   rot_z,
    output logic                          saturated,
    output logic                          last_out
);

    localparam int QB    = qvr_pkg::QUAT_BITS;
    localparam int MW    = qvr_pkg::MAT_W;
    localparam int NS    = qvr_pkg::NSTG;
    localparam int PW1   = MW + VEC_WIDTH + 1;
    localparam int FW1   = 2 * QUAT_FRAC_BITS + 1;
    localparam int ACC_W = (PW1 > FW1) ? PW1 : FW1;

    // configuration registers
    logic signed [QB-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic                 cfg_wr;
    qvr_pkg::reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = qvr_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= qvr_pkg::QUAT_W_RESET;
            quat_x_reg <= qvr_pkg::QUAT_V_RESET;
            quat_y_reg <= qvr_pkg::QUAT_V_RESET;
            quat_z_reg <= qvr_pkg::QUAT_V_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                qvr_pkg::REG_QUAT_W: quat_w_reg <= pwdata[QB-1:0];
                qvr_pkg::REG_QUAT_X: quat_x_reg <= pwdata[QB-1:0];
                qvr_pkg::REG_QUAT_Y: quat_y_reg <= pwdata[QB-1:0];
                qvr_pkg::REG_QUAT_Z: quat_z_reg <= pwdata[QB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            qvr_pkg::REG_QUAT_W: prdata = {{(qvr_pkg::DATA_W - QB){1'b0}}, quat_w_reg};
            qvr_pkg::REG_QUAT_X: prdata = {{(qvr_pkg::DATA_W - QB){1'b0}}, quat_x_reg};
            qvr_pkg::REG_QUAT_Y: prdata = {{(qvr_pkg::DATA_W - QB){1'b0}}, quat_y_reg};
            qvr_pkg::REG_QUAT_Z: prdata = {{(qvr_pkg::DATA_W - QB){1'b0}}, quat_z_reg};
            default:             prdata = '0;
        endcase
    end

    // stage valid bits and load enables; a stage loads when it is empty
    // or its content moves on in the same cycle
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = ~vld_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    qvr_pkg::stg_ctrl_t ctrl_coef, ctrl_mac;

    assign ctrl_coef.en_a = en[0];
    assign ctrl_coef.en_b = en[1];
    assign ctrl_mac.en_a  = en[2];
    assign ctrl_mac.en_b  = en[3];

    logic signed [VEC_WIDTH-1:0] vec_in [3];
    logic signed [MW-1:0]        mat    [9];
    logic signed [VEC_WIDTH-1:0] vec_b  [3];
    logic                        last_b;
    logic signed [ACC_W-1:0]     acc    [3];
    logic                        last_d;
    logic signed [VEC_WIDTH-1:0] rot    [3];

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;

    qvr_coef #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_coef (
        .clk      (clk),
        .ctrl     (ctrl_coef),
        .quat_w   (quat_w_reg),
        .quat_x   (quat_x_reg),
        .quat_y   (quat_y_reg),
        .quat_z   (quat_z_reg),
        .vec_in   (vec_in),
        .last_in  (last_vector),
        .mat_out  (mat),
        .vec_out  (vec_b),
        .last_out (last_b)
    );

    qvr_mac #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .ACC_W          (ACC_W)
    ) u_mac (
        .clk      (clk),
        .ctrl     (ctrl_mac),
        .mat_in   (mat),
        .vec_in   (vec_b),
        .last_in  (last_b),
        .acc_out  (acc),
        .last_out (last_d)
    );

    qvr_sat #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .ACC_W          (ACC_W)
    ) u_sat (
        .clk      (clk),
        .en       (en[NS-1]),
        .acc_in   (acc),
        .last_in  (last_d),
        .rot_out  (rot),
        .sat_out  (saturated),
        .last_out (last_out)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

    // an empty output stage never holds off input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NS-1] |-> in_ready)
        else $error("in_ready low with empty output stage");

    // an input transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted vector lost at first stage");

    // a result transfer with no input transfer drops occupancy by one
    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !(in_valid && in_ready))
        |=> ($countones(vld_reg) == $past($countones(vld_reg)) - 1))
        else $error("pipeline occupancy mismatch on drain");

    // with input and output both idle, occupancy holds
    a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!(out_valid && out_ready) && !(in_valid && in_ready))
        |=> ($countones(vld_reg) == $past($countones(vld_reg))))
        else $error("pipeline occupancy changed without a transfer");

endmodule

[sv/qvr_coef.sv]
// ----------------------------------------------------------------------------
// qvr_coef
// Quaternion product stage and rotation matrix stage. Forms the ten
// pairwise quaternion products, then the nine matrix entries of
// q * (0,v) * conj(q). The vector and flag ride along.
// ----------------------------------------------------------------------------
module qvr_coef #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                                clk,
    input  qvr_pkg::stg_ctrl_t                  ctrl,
    input  logic signed [qvr_pkg::QUAT_BITS-1:0] quat_w,
    input  logic signed [qvr_pkg::QUAT_BITS-1:0] quat_x,
    input  logic signed [qvr_pkg::QUAT_BITS-1:0] quat_y,
    input  logic signed [qvr_pkg::QUAT_BITS-1:0] quat_z,
    input  logic signed [VEC_WIDTH-1:0]          vec_in [3],
    input  logic                                 last_in,
    output logic signed [qvr_pkg::MAT_W-1:0]     mat_out [9],
    output logic signed [VEC_WIDTH-1:0]          vec_out [3],
    output logic                                 last_out
);

    localparam int PQ = 2 * qvr_pkg::QUAT_BITS;
    localparam int MW = qvr_pkg::MAT_W;

    logic signed [PQ-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PQ-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [PQ-1:0] ww_next, xx_next, yy_next, zz_next;
    logic signed [PQ-1:0] xy_next, wz_next, xz_next, wy_next, yz_next, wx_next;
    logic signed [VEC_WIDTH-1:0] vec_a_reg [3];
    logic                        last_a_reg;

    logic signed [MW-1:0]        mat_reg  [9];
    logic signed [MW-1:0]        mat_next [9];
    logic signed [VEC_WIDTH-1:0] vec_b_reg [3];
    logic                        last_b_reg;

    always_comb
    begin
        ww_next = quat_w * quat_w;
        xx_next = quat_x * quat_x;
        yy_next = quat_y * quat_y;
        zz_next = quat_z * quat_z;
        xy_next = quat_x * quat_y;
        wz_next = quat_w * quat_z;
        xz_next = quat_x * quat_z;
        wy_next = quat_w * quat_y;
        yz_next = quat_y * quat_z;
        wx_next = quat_w * quat_x;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_a)
        begin
            ww_reg     <= ww_next;
            xx_reg     <= xx_next;
            yy_reg     <= yy_next;
            zz_reg     <= zz_next;
            xy_reg     <= xy_next;
            wz_reg     <= wz_next;
            xz_reg     <= xz_next;
            wy_reg     <= wy_next;
            yz_reg     <= yz_next;
            wx_reg     <= wx_next;
            vec_a_reg  <= vec_in;
            last_a_reg <= last_in;
        end
    end

    // row-major 3x3 matrix; off-diagonal terms are doubled
    always_comb
    begin
        mat_next[0] = MW'(ww_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        mat_next[1] = (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        mat_next[2] = (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        mat_next[3] = (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        mat_next[4] = MW'(ww_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        mat_next[5] = (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        mat_next[6] = (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        mat_next[7] = (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        mat_next[8] = MW'(ww_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_b)
        begin
            mat_reg    <= mat_next;
            vec_b_reg  <= vec_a_reg;
            last_b_reg <= last_a_reg;
        end
    end

    assign mat_out  = mat_reg;
    assign vec_out  = vec_b_reg;
    assign last_out = last_b_reg;

endmodule

[sv/qvr_mac.sv]
// ----------------------------------------------------------------------------
// qvr_mac
// Matrix-vector multiply stage and row accumulate stage. Nine products
// are registered, then each row is summed with the rounding offset.
// ----------------------------------------------------------------------------
module qvr_mac #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ACC_W          = 2 * qvr_pkg::MAT_W + 2 * QUAT_FRAC_BITS
) (
    input  logic                             clk,
    input  qvr_pkg::stg_ctrl_t               ctrl,
    input  logic signed [qvr_pkg::MAT_W-1:0] mat_in [9],
    input  logic signed [VEC_WIDTH-1:0]      vec_in [3],
    input  logic                             last_in,
    output logic signed [ACC_W-1:0]          acc_out [3],
    output logic                             last_out
);

    localparam int PW = qvr_pkg::MAT_W + VEC_WIDTH;
    // half an output LSB, added before the shift
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (2 * QUAT_FRAC_BITS - 1);

    logic signed [PW-1:0]    prod_reg  [9];
    logic signed [PW-1:0]    prod_next [9];
    logic                    last_c_reg;
    logic signed [ACC_W-1:0] acc_reg  [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic                    last_d_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            prod_next[i] = PW'(mat_in[i]) * PW'(vec_in[i % 3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_a)
        begin
            prod_reg   <= prod_next;
            last_c_reg <= last_in;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(prod_reg[3 * r]) + ACC_W'(prod_reg[3 * r + 1])
                        + ACC_W'(prod_reg[3 * r + 2]) + RND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_b)
        begin
            acc_reg    <= acc_next;
            last_d_reg <= last_c_reg;
        end
    end

    assign acc_out  = acc_reg;
    assign last_out = last_d_reg;

endmodule

[sv/qvr_sat.sv]
// ----------------------------------------------------------------------------
// qvr_sat
// Output stage. Drops the fraction bits of each rounded row sum, clips
// to the vector width and registers the result with the clip flag.
// ----------------------------------------------------------------------------
module qvr_sat #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
    parameter int ACC_W          = 2 * qvr_pkg::MAT_W + 2 * QUAT_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [ACC_W-1:0]     acc_in [3],
    input  logic                        last_in,
    output logic signed [VEC_WIDTH-1:0] rot_out [3],
    output logic                        sat_out,
    output logic                        last_out
);

    localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) <<< (VEC_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MINV = -(ACC_W'(1) <<< (VEC_WIDTH - 1));

    logic signed [ACC_W-1:0]     sh       [3];
    logic signed [VEC_WIDTH-1:0] rot_reg  [3];
    logic signed [VEC_WIDTH-1:0] rot_next [3];
    logic                        sat_reg, sat_next;
    logic                        last_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            sh[r] = acc_in[r] >>> (2 * QUAT_FRAC_BITS);
            if (sh[r] > MAXV)
            begin
                rot_next[r] = MAXV[VEC_WIDTH-1:0];
                sat_next    = 1'b1;
            end
            else if (sh[r] < MINV)
            begin
                rot_next[r] = MINV[VEC_WIDTH-1:0];
                sat_next    = 1'b1;
            end
            else
            begin
                rot_next[r] = sh[r][VEC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            sat_reg  <= sat_next;
            last_reg <= last_in;
        end
    end

    assign rot_out  = rot_reg;
    assign sat_out  = sat_reg;
    assign last_out = last_reg;

endmodule

[sim/tb_quaternion_vector_rotate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_unit
// Streams vectors through the rotate unit under a series of quaternions set
// over APB, with bursty input and output backpressure. A scoreboard forms the
// rotation matrix from its own copy of the quaternion, predicts each rotated,
// rounded and saturated vector, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_unit;

    localparam int VW              = qvr_pkg::VEC_WIDTH_DEF;
    localparam int FRAC            = qvr_pkg::QUAT_FRAC_BITS_DEF;
    localparam int QB              = qvr_pkg::QUAT_BITS;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 158;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 last;
    } vec_item_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 sat;
        logic                 last;
    } rot_item_t;

    typedef struct packed {
        logic signed [QB-1:0] w;
        logic signed [QB-1:0] x;
        logic signed [QB-1:0] y;
        logic signed [QB-1:0] z;
    } quat_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PATTERN,
        READY_RARELY
    } ready_mode_t;

    class rotation_scoreboard;
        quat_t     quat;
        rot_item_t expected_rot_q[$];
        int        mismatch_count;

        function new();
            quat           = '{qvr_pkg::QUAT_W_RESET, qvr_pkg::QUAT_V_RESET,
                               qvr_pkg::QUAT_V_RESET, qvr_pkg::QUAT_V_RESET};
            mismatch_count = 0;
        endfunction

        function void set_component(qvr_pkg::reg_idx_t idx, logic [QB-1:0] value);
            case (idx)
                qvr_pkg::REG_QUAT_W: quat.w = value;
                qvr_pkg::REG_QUAT_X: quat.x = value;
                qvr_pkg::REG_QUAT_Y: quat.y = value;
                qvr_pkg::REG_QUAT_Z: quat.z = value;
                default: ;
            endcase
        endfunction

        // v' = R(q) * v at scale 2^(2*FRAC), round half up, then clip
        function rot_item_t rotate_vector(vec_item_t v);
            longint    w, x, y, z;
            longint    m[3][3];
            longint    vin[3];
            longint    acc;
            longint    vmax;
            longint    vmin;
            logic signed [VW-1:0] res[3];
            rot_item_t r;
            w      = quat.w;
            x      = quat.x;
            y      = quat.y;
            z      = quat.z;
            vin[0] = v.x;
            vin[1] = v.y;
            vin[2] = v.z;
            vmax   = (longint'(1) <<< (VW - 1)) - 1;
            vmin   = -vmax - 1;
            m[0][0] = w * w + x * x - y * y - z * z;
            m[0][1] = 2 * (x * y - w * z);
            m[0][2] = 2 * (x * z + w * y);
            m[1][0] = 2 * (x * y + w * z);
            m[1][1] = w * w - x * x + y * y - z * z;
            m[1][2] = 2 * (y * z - w * x);
            m[2][0] = 2 * (x * z - w * y);
            m[2][1] = 2 * (y * z + w * x);
            m[2][2] = w * w - x * x - y * y + z * z;
            r.sat = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc = m[i][0] * vin[0] + m[i][1] * vin[1] + m[i][2] * vin[2];
                acc = (acc + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
                if (acc > vmax)
                begin
                    acc   = vmax;
                    r.sat = 1'b1;
                end
                else if (acc < vmin)
                begin
                    acc   = vmin;
                    r.sat = 1'b1;
                end
                res[i] = acc[VW-1:0];
            end
            r.x    = res[0];
            r.y    = res[1];
            r.z    = res[2];
            r.last = v.last;
            return r;
        endfunction

        function void note_vector(vec_item_t v);
            expected_rot_q.push_back(rotate_vector(v));
        endfunction

        function void compare_field(string name, logic signed [31:0] exp_val,
                                    logic signed [31:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t %s mismatch: expected %0d actual %0d",
                         $time, name, exp_val, act_val);
                mismatch_count++;
            end
        endfunction

        function void check_rotation(rot_item_t got);
            rot_item_t exp_rot;
            if (expected_rot_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %0d %0d %0d",
                         $time, got.x, got.y, got.z);
                mismatch_count++;
                return;
            end
            exp_rot = expected_rot_q.pop_front();
            compare_field("rot_x", exp_rot.x, got.x);
            compare_field("rot_y", exp_rot.y, got.y);
            compare_field("rot_z", exp_rot.z, got.z);
            compare_field("saturated", exp_rot.sat, got.sat);
            compare_field("last_out", exp_rot.last, got.last);
        endfunction

        function int pending();
            return expected_rot_q.size();
        endfunction
    endclass

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [qvr_pkg::ADDR_W-1:0]    paddr       = '0;
    logic [qvr_pkg::DATA_W-1:0]    pwdata      = '0;
    logic [qvr_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic signed [VW-1:0]          vec_x       = '0;
    logic signed [VW-1:0]          vec_y       = '0;
    logic signed [VW-1:0]          vec_z       = '0;
    logic                          last_vector = 1'b0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic signed [VW-1:0]          rot_x;
    logic signed [VW-1:0]          rot_y;
    logic signed [VW-1:0]          rot_z;
    logic                          saturated;
    logic                          last_out;

    rotation_scoreboard sb;
    ready_mode_t        stall_mode    = READY_ALWAYS;
    logic [15:0]        stall_pattern = 16'hffff;
    int                 pat_idx       = 0;
    int                 gap_max       = 0;
    int                 burst_left    = 0;
    int                 cycle_count   = 0;

    vec_item_t directed_vecs [6] = '{
        '{16'sd32767, -16'sd32768, 16'sd0, 1'b1},
        '{-16'sd32768, 16'sd32767, -16'sd1, 1'b0},
        '{16'sd2, -16'sd2, 16'sd3, 1'b1},
        '{-16'sd1, 16'sd1, -16'sd3, 1'b0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1}
    };

    // unit rotations: identity, 90 deg about each axis, 180 deg, 120 deg
    quat_t unit_quats [8] = '{
        '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0},
        '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0},
        '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
        '{16'sd0, 16'sd16384, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd16384, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd16384},
        '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}
    };

    quaternion_vector_rotate_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .last_vector (last_vector),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rot_x       (rot_x),
        .rot_y       (rot_y),
        .rot_z       (rot_z),
        .saturated   (saturated),
        .last_out    (last_out)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        case (stall_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN:
            begin
                out_ready <= stall_pattern[pat_idx];
                pat_idx   <= (pat_idx + 1) % 16;
            end
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : result_monitor
        rot_item_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.x    = rot_x;
            seen.y    = rot_y;
            seen.z    = rot_z;
            seen.sat  = saturated;
            seen.last = last_out;
            sb.check_rotation(seen);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // upper data bits are junk the register must drop
    task automatic write_reg(input qvr_pkg::reg_idx_t idx, input logic [QB-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_component(idx, value);
    endtask

    task automatic write_quat(input quat_t q);
        write_reg(qvr_pkg::REG_QUAT_W, q.w);
        write_reg(qvr_pkg::REG_QUAT_X, q.x);
        write_reg(qvr_pkg::REG_QUAT_Y, q.y);
        write_reg(qvr_pkg::REG_QUAT_Z, q.z);
    endtask

    // hold valid until the transfer, then maybe drop it for a gap
    task automatic push_vector(input vec_item_t item);
        in_valid    <= 1'b1;
        vec_x       <= item.x;
        vec_y       <= item.y;
        vec_z       <= item.z;
        last_vector <= item.last;
        do @(posedge clk); while (!in_ready);
        sb.note_vector(item);
        if (gap_max > 0 && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (qvr_pkg::NSTG + 2) @(posedge clk);
    endtask

    function automatic logic signed [VW-1:0] rand_word(input int kind);
        case (kind)
            0: return VW'($urandom);
            1: return VW'($urandom_range(0, 128) - 64);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sd32767;
                    1: return -16'sd32768;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_kind();
        int roll;
        roll = $urandom_range(0, 9);
        return (roll < 6) ? 0 : ((roll < 8) ? 1 : 2);
    endfunction

    function automatic vec_item_t rand_vector();
        vec_item_t v;
        v.x    = rand_word(pick_kind());
        v.y    = rand_word(pick_kind());
        v.z    = rand_word(pick_kind());
        v.last = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    function automatic quat_t rand_quat(input int mode);
        quat_t q;
        case (mode)
            0: q = '{rand_word(0), rand_word(0), rand_word(0), rand_word(0)};
            1:
            begin
                q = unit_quats[$urandom_range(0, 7)];
                if ($urandom_range(0, 1)) q.w = -q.w;
                if ($urandom_range(0, 1)) q.x = -q.x;
                if ($urandom_range(0, 1)) q.y = -q.y;
                if ($urandom_range(0, 1)) q.z = -q.z;
            end
            2: q = '{rand_word(2), rand_word(2), rand_word(2), rand_word(2)};
            default:
            begin
                q.w = QB'($urandom_range(0, 8192) - 4096);
                q.x = QB'($urandom_range(0, 8192) - 4096);
                q.y = QB'($urandom_range(0, 8192) - 4096);
                q.z = QB'($urandom_range(0, 8192) - 4096);
            end
        endcase
        return q;
    endfunction

    task automatic run_directed();
        foreach (directed_vecs[i]) push_vector(directed_vecs[i]);
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // identity after reset, no write yet
        run_directed();
        // w = 0.5 scales by 1/4: odd multiples of two land on exact ties
        stall_mode = READY_MOSTLY;
        gap_max    = 2;
        write_quat('{16'sd8192, 16'sd0, 16'sd0, 16'sd0});
        run_directed();
        stall_mode = READY_PATTERN;
        write_quat('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
        run_directed();
        stall_mode = READY_RARELY;
        write_quat('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            write_quat(rand_quat(p % 4));
            stall_mode    = ready_mode_t'((p / 4 + p) % 4);
            stall_pattern = 16'($urandom) | 16'h0001;
            gap_max       = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 12);
            burst_left    = 0;
            repeat (ITEMS_PER_PHASE) push_vector(rand_vector());
            drain();
        end

        if (sb.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
